[src/c8asm_pkg.sv]
package c8asm_pkg;

  // operand tokens kept per line, three characters each
  localparam int MAX_OPERAND_TOKENS = 4;
  localparam int OPND_CHARS = 3;
  localparam int MNEM_LEN = 5;
  // token counter saturates at MAX_OPERAND_TOKENS + 2
  localparam int TOK_MAX = MAX_OPERAND_TOKENS + 2;
  localparam int TOK_W = $clog2(TOK_MAX + 1);
  localparam int CIC_W = $clog2(MNEM_LEN + 1);

  // characters with a meaning of their own
  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_SP = 8'd32;
  localparam logic [7:0] CHAR_COMMA = 8'd44;

  // text of the current line as gathered so far
  typedef struct packed {
    logic [TOK_W-1:0] tok_cnt;
    logic too_long;
    logic [0:MNEM_LEN-1][7:0] mnem;
    logic [0:MAX_OPERAND_TOKENS-1][0:OPND_CHARS-1][7:0] opnd;
    logic has_chars;
  } line_state_t;

endpackage

[src/c8asm_tokenizer.sv]
module c8asm_tokenizer
  import c8asm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  text_char,
  output line_state_t line_st
);

  line_state_t st_r, st_nxt;
  logic inside_r, inside_nxt;
  logic [CIC_W-1:0] cic_r, cic_nxt;
  logic [TOK_W-1:0] tc_new;
  logic [CIC_W-1:0] cic_cur;

  // token split and character capture for one word
  always_comb begin
    st_nxt = st_r;
    inside_nxt = inside_r;
    cic_nxt = cic_r;
    tc_new = st_r.tok_cnt;
    cic_cur = cic_r;
    if (step) begin
      if (text_char == CHAR_NL) begin
        st_nxt = '0;
        inside_nxt = 1'b0;
        cic_nxt = '0;
      end else begin
        st_nxt.has_chars = 1'b1;
        if (text_char == CHAR_SP || text_char == CHAR_COMMA) begin
          inside_nxt = 1'b0;
        end else begin
          // a new token starts
          if (!inside_r) begin
            inside_nxt = 1'b1;
            cic_cur = '0;
            if (st_r.tok_cnt < TOK_W'(TOK_MAX)) begin
              tc_new = st_r.tok_cnt + TOK_W'(1);
            end
          end
          st_nxt.tok_cnt = tc_new;
          cic_nxt = cic_cur;
          if (tc_new == TOK_W'(1)) begin
            // mnemonic
            if (cic_cur < CIC_W'(MNEM_LEN)) begin
              for (int i = 0; i < MNEM_LEN; i++) begin
                if (cic_cur == CIC_W'(i)) st_nxt.mnem[i] = text_char;
              end
              cic_nxt = cic_cur + CIC_W'(1);
            end else begin
              st_nxt.too_long = 1'b1;
            end
          end else if (cic_cur < CIC_W'(OPND_CHARS)) begin
            // operand characters, first three only
            for (int k = 0; k < MAX_OPERAND_TOKENS; k++) begin
              for (int j = 0; j < OPND_CHARS; j++) begin
                if (tc_new == TOK_W'(k + 2) && cic_cur == CIC_W'(j)) begin
                  st_nxt.opnd[k][j] = text_char;
                end
              end
            end
            if (tc_new <= TOK_W'(MAX_OPERAND_TOKENS + 1)) begin
              cic_nxt = cic_cur + CIC_W'(1);
            end
          end
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      inside_r <= 1'b0;
      cic_r <= '0;
    end else begin
      st_r <= st_nxt;
      inside_r <= inside_nxt;
      cic_r <= cic_nxt;
    end
  end

  assign line_st = st_r;

endmodule

[src/c8asm_encoder.sv]
module c8asm_encoder
  import c8asm_pkg::*;
(
  input  line_state_t line_st,
  output logic [15:0] opcode_word,
  output logic        line_error
);

  typedef enum logic [4:0] {
    MN_CLS, MN_RET, MN_SYS, MN_JP, MN_CALL, MN_SE, MN_SNE, MN_LD, MN_ADD, MN_OR,
    MN_AND, MN_XOR, MN_SUB, MN_SHR, MN_SUBN, MN_SHL, MN_RND, MN_DRW, MN_SKP,
    MN_SKNP, MN_NONE
  } mnem_t;

  localparam int MNEM_CNT = 20;
  localparam logic [0:MNEM_CNT-1][8*MNEM_LEN-1:0] MNEM_TABLE = {
    {"CLS", 16'h0}, {"RET", 16'h0}, {"SYS", 16'h0}, {"JP", 24'h0},
    {"CALL", 8'h0}, {"SE", 24'h0}, {"SNE", 16'h0}, {"LD", 24'h0},
    {"ADD", 16'h0}, {"OR", 24'h0}, {"AND", 16'h0}, {"XOR", 16'h0},
    {"SUB", 16'h0}, {"SHR", 16'h0}, {"SUBN", 8'h0}, {"SHL", 16'h0},
    {"RND", 16'h0}, {"DRW", 16'h0}, {"SKP", 16'h0}, {"SKNP", 8'h0}
  };

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [15:0] OP_JP = 16'h1000;
  localparam logic [15:0] OP_JP_V0 = 16'hB000;
  localparam logic [15:0] OP_CALL = 16'h2000;
  localparam logic [15:0] OP_SE_B = 16'h3000;
  localparam logic [15:0] OP_SNE_B = 16'h4000;
  localparam logic [15:0] OP_SE_R = 16'h5000;
  localparam logic [15:0] OP_SNE_R = 16'h9000;
  localparam logic [15:0] OP_LD_B = 16'h6000;
  localparam logic [15:0] OP_ADD_B = 16'h7000;
  localparam logic [15:0] OP_LD_R = 16'h8000;
  localparam logic [15:0] OP_OR = 16'h8001;
  localparam logic [15:0] OP_AND = 16'h8002;
  localparam logic [15:0] OP_XOR = 16'h8003;
  localparam logic [15:0] OP_ADD_R = 16'h8004;
  localparam logic [15:0] OP_SUB = 16'h8005;
  localparam logic [15:0] OP_SHR = 16'h8006;
  localparam logic [15:0] OP_SUBN = 16'h8007;
  localparam logic [15:0] OP_SHL = 16'h800E;
  localparam logic [15:0] OP_LD_I = 16'hA000;
  localparam logic [15:0] OP_RND = 16'hC000;
  localparam logic [15:0] OP_DRW = 16'hD000;
  localparam logic [15:0] OP_SKP = 16'hE09E;
  localparam logic [15:0] OP_SKNP = 16'hE0A1;
  localparam logic [15:0] OP_LD_DT_R = 16'hF007;
  localparam logic [15:0] OP_LD_K = 16'hF00A;
  localparam logic [15:0] OP_LD_DT_W = 16'hF015;
  localparam logic [15:0] OP_LD_ST = 16'hF018;
  localparam logic [15:0] OP_ADD_I = 16'hF01E;
  localparam logic [15:0] OP_LD_F = 16'hF029;
  localparam logic [15:0] OP_LD_BCD = 16'hF033;
  localparam logic [15:0] OP_LD_STORE = 16'hF055;
  localparam logic [15:0] OP_LD_LOAD = 16'hF065;
  localparam logic [15:0] OP_ERR = 16'hFFFF;

  // uppercase hex digit value, anything else reads as zero
  function automatic logic [3:0] hexv(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'h0;
    if (ch inside {["0":"9"]}) v = 4'(ch - 8'h30);
    else if (ch inside {["A":"F"]}) v = 4'(ch - 8'h37);
    return v;
  endfunction

  mnem_t mn;
  logic have1, have2, have3;
  logic r0, r1, r2;
  logic [3:0] x, h11, h20, h21;
  logic [7:0] b1;
  logic [11:0] a0, a1;
  logic [7:0] c00, c10;
  logic ok;
  logic [15:0] code;

  // mnemonic lookup
  always_comb begin
    mn = MN_NONE;
    for (int m = MNEM_CNT - 1; m >= 0; m--) begin
      if (line_st.mnem == MNEM_TABLE[m]) mn = mnem_t'(m);
    end
  end

  // operand fields
  always_comb begin
    c00 = line_st.opnd[0][0];
    c10 = line_st.opnd[1][0];
    r0 = c00 == "V";
    r1 = c10 == "V";
    r2 = line_st.opnd[2][0] == "V";
    x = hexv(line_st.opnd[0][1]);
    h11 = hexv(line_st.opnd[1][1]);
    h20 = hexv(line_st.opnd[2][0]);
    h21 = hexv(line_st.opnd[2][1]);
    b1 = {hexv(c10), h11};
    a0 = {hexv(c00), x, hexv(line_st.opnd[0][2])};
    a1 = {hexv(c10), h11, hexv(line_st.opnd[1][2])};
    have1 = line_st.tok_cnt >= TOK_W'(2);
    have2 = line_st.tok_cnt >= TOK_W'(3);
    have3 = line_st.tok_cnt >= TOK_W'(4);
  end

  // opcode per form
  always_comb begin
    ok = 1'b0;
    code = '0;
    case (mn)
      MN_CLS: begin
        ok = 1'b1;
        code = OP_CLS;
      end
      MN_RET: begin
        ok = 1'b1;
        code = OP_RET;
      end
      MN_SYS: begin
        ok = have1;
        code = {4'h0, a0};
      end
      MN_JP: begin
        if (!r0) begin
          ok = have1;
          code = OP_JP | {4'h0, a0};
        end else begin
          ok = have2;
          code = OP_JP_V0 | {4'h0, a1};
        end
      end
      MN_CALL: begin
        ok = have1;
        code = OP_CALL | {4'h0, a0};
      end
      MN_SE, MN_SNE: begin
        ok = r0 && have2;
        if (r1) code = ((mn == MN_SE) ? OP_SE_R : OP_SNE_R) | {4'h0, x, h11, 4'h0};
        else code = ((mn == MN_SE) ? OP_SE_B : OP_SNE_B) | {4'h0, x, b1};
      end
      MN_LD: begin
        ok = have2;
        case (c00)
          "V": begin
            case (c10)
              "V": code = OP_LD_R | {4'h0, x, h11, 4'h0};
              "D": code = OP_LD_DT_R | {4'h0, x, 8'h00};
              "K": code = OP_LD_K | {4'h0, x, 8'h00};
              "[": code = OP_LD_LOAD | {4'h0, x, 8'h00};
              default: code = OP_LD_B | {4'h0, x, b1};
            endcase
          end
          "I": code = OP_LD_I | {4'h0, a1};
          "D": code = OP_LD_DT_W | {4'h0, h11, 8'h00};
          "S": code = OP_LD_ST | {4'h0, h11, 8'h00};
          "F": code = OP_LD_F | {4'h0, h11, 8'h00};
          "B": code = OP_LD_BCD | {4'h0, h11, 8'h00};
          "[": code = OP_LD_STORE | {4'h0, h11, 8'h00};
          default: ok = 1'b0;
        endcase
      end
      MN_ADD: begin
        if (c00 == "I") begin
          ok = have2;
          code = OP_ADD_I | {4'h0, h11, 8'h00};
        end else begin
          ok = have2 && r0;
          if (r1) code = OP_ADD_R | {4'h0, x, h11, 4'h0};
          else code = OP_ADD_B | {4'h0, x, b1};
        end
      end
      MN_OR, MN_AND, MN_XOR, MN_SUB, MN_SUBN: begin
        ok = r0 && have2 && r1;
        case (mn)
          MN_OR: code = OP_OR;
          MN_AND: code = OP_AND;
          MN_XOR: code = OP_XOR;
          MN_SUB: code = OP_SUB;
          default: code = OP_SUBN;
        endcase
        code = code | {4'h0, x, h11, 4'h0};
      end
      MN_SHR, MN_SHL: begin
        ok = r0 && have3 && r2;
        code = ((mn == MN_SHR) ? OP_SHR : OP_SHL) | {4'h0, x, h21, 4'h0};
      end
      MN_RND: begin
        ok = r0 && have2;
        code = OP_RND | {4'h0, x, b1};
      end
      MN_DRW: begin
        ok = r0 && have3 && r1;
        code = OP_DRW | {4'h0, x, h11, h20};
      end
      MN_SKP, MN_SKNP: begin
        ok = r0 && have1;
        code = ((mn == MN_SKP) ? OP_SKP : OP_SKNP) | {4'h0, x, 8'h00};
      end
      default: ok = 1'b0;
    endcase
    if (line_st.too_long || line_st.tok_cnt == '0) ok = 1'b0;
  end

  assign opcode_word = ok ? code : OP_ERR;
  assign line_error = !ok;

endmodule

[src/chip8_line_assembler.sv]
// CHIP-8 line assembler. Source text enters one byte per word on the in_
// channel; spaces and commas split tokens and a newline (byte 10) ends the
// line, at which point one word leaves on the out_ channel carrying the
// 16-bit opcode (0xFFFF with out_line_error set when the line is bad). A bare
// newline produces nothing. Throughput is one text byte per cycle while the
// input side is not stalled: each byte is held in an input register, then
// updates the line state, and the opcode is encoded from that state straight
// into the output register as the newline leaves the input register. The
// input side only stalls when an opcode is due and the output register is
// still full and not being taken.
module chip8_line_assembler
  import c8asm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_opcode_word,
  output logic        out_line_error
);

  logic s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_opcode_r;
  logic out_error_r;
  line_state_t line_st;
  logic [15:0] enc_code;
  logic enc_err;
  logic emits, s1_go;

  c8asm_tokenizer u_tok (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_go),
    .text_char(s1_char_r),
    .line_st  (line_st)
  );

  c8asm_encoder u_enc (
    .line_st    (line_st),
    .opcode_word(enc_code),
    .line_error (enc_err)
  );

  // handshake: a newline on a non-empty line needs room in the output register
  always_comb begin
    emits = (s1_char_r == CHAR_NL) && line_st.has_chars;
    s1_go = s1_valid_r && (!emits || !out_valid_r || out_ready);
    in_ready = !s1_valid_r || s1_go;
    s1_valid_nxt = in_valid || (s1_valid_r && !s1_go);
    if (s1_go && emits) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_text_char;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emits) begin
      out_opcode_r <= enc_code;
      out_error_r <= enc_err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_opcode_word = out_opcode_r;
  assign out_line_error = out_error_r;

endmodule
